[hw/rtl/lfod_pkg.sv]
package lfod_pkg;

    localparam int LineCapacityDefault = 63;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

endpackage

[hw/rtl/line_framer_with_overflow_drop_top.sv]
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid, in_ready  | data_byte[7:0]
// output  | out       | out_valid, out_ready| line_byte[7:0], last_of_line
//
// Each accepted input word goes into the cell at the fill position, except in drop mode.
// A newline ends the line, and the row of cells then shifts one word a cycle toward
// the head while the output is ready. The input is not ready while a line is being sent.
// Reset clears the fill count, the drop mode and the sending state; cell contents
// are not reset. A stalled output holds its word, since the row shifts only on acceptance.
module line_framer_with_overflow_drop_top #(
    parameter int LINE_CAPACITY = lfod_pkg::LineCapacityDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       last_of_line
);

    localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

    lfod_pkg::cell_ctrl_t ctrl;
    logic [CNT_W-1:0]     fill;
    logic [7:0]           q [LINE_CAPACITY];

    lfod_ctrl #(
        .LINE_CAPACITY(LINE_CAPACITY),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .last_of_line(last_of_line),
        .ctrl        (ctrl),
        .fill        (fill)
    );

    for (genvar i = 0; i < LINE_CAPACITY; i++)
    begin : g_cell
        logic [7:0] nbr;
        if (i == LINE_CAPACITY - 1)
        begin : g_tail
            assign nbr = q[i];
        end
        else
        begin : g_mid
            assign nbr = q[i+1];
        end
        lfod_cell #(
            .IDX  (i),
            .CNT_W(CNT_W)
        ) u_cell (
            .clk (clk),
            .ctrl(ctrl),
            .fill(fill),
            .din (data_byte),
            .nbr (nbr),
            .q   (q[i])
        );
    end

    assign line_byte = q[0];

endmodule

[hw/rtl/lfod_cell.sv]
module lfod_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic               clk,
    input  lfod_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]   fill,
    input  logic [7:0]         din,
    input  logic [7:0]         nbr,
    output logic [7:0]         q
);

    logic [7:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            q_reg <= nbr;
        end
        else if (ctrl.load && (fill == CNT_W'(IDX)))
        begin
            q_reg <= din;
        end
    end

    assign q = q_reg;

endmodule

[hw/rtl/lfod_ctrl.sv]
module lfod_ctrl #(
    parameter int LINE_CAPACITY = lfod_pkg::LineCapacityDefault,
    parameter int CNT_W         = $clog2(LINE_CAPACITY + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 last_of_line,
    output lfod_pkg::cell_ctrl_t ctrl,
    output logic [CNT_W-1:0]     fill
);

    lfod_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             drop_reg, drop_next;
    logic             in_acc;
    logic             out_acc;
    logic             is_nl;
    logic [CNT_W-1:0] fill_inc;

    assign in_ready     = (state_reg == lfod_pkg::ST_FILL);
    assign out_valid    = (state_reg == lfod_pkg::ST_EMIT);
    assign in_acc       = in_valid && in_ready;
    assign out_acc      = out_valid && out_ready;
    assign is_nl        = (data_byte == lfod_pkg::NEWLINE_CODE);
    assign fill_inc     = fill_reg + CNT_W'(1);
    assign last_of_line = (remain_reg == CNT_W'(1));
    assign ctrl.load    = in_acc && !drop_reg;
    assign ctrl.shift   = out_acc;
    assign fill         = fill_reg;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        drop_next   = drop_reg;
        case (state_reg)
            lfod_pkg::ST_FILL:
            begin
                if (in_acc)
                begin
                    if (drop_reg)
                    begin
                        if (is_nl)
                        begin
                            drop_next = 1'b0;
                        end
                    end
                    else if (is_nl)
                    begin
                        remain_next = fill_inc;
                        fill_next   = '0;
                        state_next  = lfod_pkg::ST_EMIT;
                    end
                    else if (fill_inc >= CNT_W'(LINE_CAPACITY))
                    begin
                        fill_next = '0;
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            lfod_pkg::ST_EMIT:
            begin
                if (out_acc)
                begin
                    remain_next = remain_reg - CNT_W'(1);
                    if (last_of_line)
                    begin
                        state_next = lfod_pkg::ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = lfod_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lfod_pkg::ST_FILL;
            fill_reg   <= '0;
            remain_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
            drop_reg   <= drop_next;
        end
    end

endmodule

[hw/rtl/lfod_checker.sv]
module lfod_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] data_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] line_byte,
    input logic       last_of_line
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("Input is ready while a line is being sent.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(line_byte)
                                       && $stable(last_of_line)))
        else $error("Stalled output word changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_of_line) |-> (line_byte == lfod_pkg::NEWLINE_CODE))
        else $error("Last word of a line is not a newline.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_line) |=> out_valid)
        else $error("Line ended before its last word.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (data_byte != lfod_pkg::NEWLINE_CODE)) |=> !out_valid)
        else $error("Output started without a newline.");

endmodule

bind line_framer_with_overflow_drop_top lfod_checker u_lfod_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .line_byte   (line_byte),
    .last_of_line(last_of_line)
);
